@@ rtl/mi3_pkg.sv @@
// Shared types and constants for the 3x3 matrix inverse block.
package mi3_pkg;

    // Entry width is fixed by the transaction format.
    localparam int W = 32;
    localparam int FRAC_BITS_DEF = 16;
    // Adjugate entry width: difference of two full products.
    localparam int AW = 2 * W + 1;
    // Determinant width: three (W x AW) products summed, with headroom.
    localparam int DW = 3 * W + 3;

    typedef logic signed [W-1:0] elem_t;

    typedef struct packed {
        elem_t a00;
        elem_t a01;
        elem_t a02;
        elem_t a10;
        elem_t a11;
        elem_t a12;
        elem_t a20;
        elem_t a21;
        elem_t a22;
    } in_t;

    typedef struct packed {
        elem_t inv00;
        elem_t inv01;
        elem_t inv02;
        elem_t inv10;
        elem_t inv11;
        elem_t inv12;
        elem_t inv20;
        elem_t inv21;
        elem_t inv22;
        logic  singular;
        logic  saturated;
    } out_t;

    // Determinant as seen by the divider lanes.
    typedef struct packed {
        logic [DW-1:0] dmag;
        logic          dneg;
        logic          dzero;
    } det_info_t;

    // One lane's finished entry.
    typedef struct packed {
        logic [W-1:0] val;
        logic         sat;
        logic         zero;
    } lane_res_t;

    // Operand pairs of the 18 cofactor products, row-major entry indexes.
    // adj[k] = p[2k] - p[2k+1]
    localparam int PROD_A [18] = '{4, 5, 2, 1, 1, 2, 5, 3, 0, 2, 2, 0, 3, 4, 1, 0, 0, 1};
    localparam int PROD_B [18] = '{8, 7, 7, 8, 5, 4, 6, 8, 8, 6, 3, 5, 7, 6, 6, 7, 4, 3};

endpackage

@@ rtl/mi3_cofactor.sv @@
// Two-stage cofactor unit: 18 products, then the nine adjugate entries.
module mi3_cofactor (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              ce,
    input  logic                              in_valid,
    input  mi3_pkg::in_t                      mat,
    output logic                              adj_valid,
    output logic signed [mi3_pkg::AW-1:0]     adj [9],
    output logic signed [mi3_pkg::W-1:0]      row0 [3]
);
    import mi3_pkg::*;

    elem_t                 m [9];
    logic signed [2*W-1:0] p_next [18];
    logic signed [2*W-1:0] p_reg [18];
    elem_t                 row0_s1_reg [3];
    elem_t                 row0_s2_reg [3];
    logic signed [AW-1:0]  adj_next [9];
    logic signed [AW-1:0]  adj_reg [9];
    logic                  v1_reg;
    logic                  v2_reg;

    always_comb begin
        m[0] = mat.a00;
        m[1] = mat.a01;
        m[2] = mat.a02;
        m[3] = mat.a10;
        m[4] = mat.a11;
        m[5] = mat.a12;
        m[6] = mat.a20;
        m[7] = mat.a21;
        m[8] = mat.a22;
        for (int j = 0; j < 18; j++) begin
            p_next[j] = m[PROD_A[j]] * m[PROD_B[j]];
        end
        for (int k = 0; k < 9; k++) begin
            adj_next[k] = AW'(p_reg[2*k]) - AW'(p_reg[2*k+1]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (ce) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            p_reg       <= p_next;
            adj_reg     <= adj_next;
            row0_s1_reg <= m[0:2];
            row0_s2_reg <= row0_s1_reg;
        end
    end

    assign adj_valid = v2_reg;
    assign adj       = adj_reg;
    assign row0      = row0_s2_reg;

endmodule

@@ rtl/mi3_det.sv @@
// Three-stage determinant unit: split products, sum, magnitude and sign.
module mi3_det (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              ce,
    input  logic                              adj_valid,
    input  logic signed [mi3_pkg::AW-1:0]     adj [9],
    input  logic signed [mi3_pkg::W-1:0]      row0 [3],
    output logic                              info_valid,
    output mi3_pkg::det_info_t                info,
    output logic signed [mi3_pkg::AW-1:0]     adj_out [9]
);
    import mi3_pkg::*;

    // adj = hi * 2^W + lo, so each row-0 term costs two W x (W+1) products
    logic signed [2*W:0]   ph_next [3];
    logic signed [2*W:0]   pl_next [3];
    logic signed [2*W:0]   ph_reg [3];
    logic signed [2*W:0]   pl_reg [3];
    logic signed [DW-1:0]  det_next;
    logic signed [DW-1:0]  det_reg;
    det_info_t             info_next;
    det_info_t             info_reg;
    logic signed [AW-1:0]  adj1_reg [9];
    logic signed [AW-1:0]  adj2_reg [9];
    logic signed [AW-1:0]  adj3_reg [9];
    logic [2:0]            v_reg;

    always_comb begin
        for (int t = 0; t < 3; t++) begin
            ph_next[t] = row0[t] * $signed(adj[3*t][AW-1:W]);
            pl_next[t] = row0[t] * $signed({1'b0, adj[3*t][W-1:0]});
        end
        det_next = '0;
        for (int t = 0; t < 3; t++) begin
            det_next = det_next + (DW'(ph_reg[t]) <<< W) + DW'(pl_reg[t]);
        end
        info_next.dneg  = det_reg[DW-1];
        info_next.dzero = (det_reg == '0);
        info_next.dmag  = det_reg[DW-1] ? (~det_reg + 1'b1) : det_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (ce) begin
            v_reg <= {v_reg[1:0], adj_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            ph_reg   <= ph_next;
            pl_reg   <= pl_next;
            det_reg  <= det_next;
            info_reg <= info_next;
            adj1_reg <= adj;
            adj2_reg <= adj1_reg;
            adj3_reg <= adj2_reg;
        end
    end

    assign info_valid = v_reg[2];
    assign info       = info_reg;
    assign adj_out    = adj3_reg;

endmodule

@@ rtl/mi3_lane.sv @@
// One divider lane: adjugate entry scaled and divided by the determinant.
module mi3_lane #(
    parameter int FRAC_BITS = mi3_pkg::FRAC_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              ce,
    input  logic                              in_valid,
    input  logic signed [mi3_pkg::AW-1:0]     adj,
    input  mi3_pkg::det_info_t                info,
    output logic                              out_valid,
    output mi3_pkg::lane_res_t                res
);
    import mi3_pkg::*;

    localparam int NW = AW + 2 * FRAC_BITS;  // scaled numerator
    localparam int QB = W + 1;               // quotient bits developed
    localparam int HW = NW - QB;             // numerator bits above the quotient

    typedef struct packed {
        logic [DW-1:0] r;
        logic [QB-1:0] low;
        logic [QB-1:0] q;
        logic [DW-1:0] dmag;
        logic          ovf;
        logic          neg;
        logic          dzero;
    } div_st_t;

    logic [NW-1:0]  num_u;
    logic [NW-1:0]  nabs_next;
    logic [NW-1:0]  nabs_reg;
    logic           neg1_reg;
    det_info_t      info1_reg;
    logic           v1_reg;
    logic [HW-1:0]  hi;
    div_st_t        st_next [QB+1];
    div_st_t        st_reg [QB+1];
    logic [QB:0]    sv_reg;
    logic [DW:0]    sh [QB];
    logic [DW:0]    diff [QB];
    logic           take [QB];
    logic [QB-1:0]  qf;
    logic           sat_pos;
    logic           sat_neg;
    logic           sat;
    logic [W-1:0]   mag;
    lane_res_t      res_next;
    lane_res_t      res_reg;
    logic           vf_reg;

    always_comb begin
        num_u     = {adj, {(2*FRAC_BITS){1'b0}}};
        nabs_next = adj[AW-1] ? (~num_u + 1'b1) : num_u;

        // quotient beyond QB bits means saturation outright
        hi               = nabs_reg[NW-1:QB];
        st_next[0].ovf   = DW'(hi) >= info1_reg.dmag;
        st_next[0].r     = st_next[0].ovf ? '0 : DW'(hi);
        st_next[0].low   = nabs_reg[QB-1:0];
        st_next[0].q     = '0;
        st_next[0].dmag  = info1_reg.dmag;
        st_next[0].neg   = neg1_reg;
        st_next[0].dzero = info1_reg.dzero;

        // restoring division, one quotient bit per stage
        for (int s = 0; s < QB; s++) begin
            sh[s]             = {st_reg[s].r, st_reg[s].low[QB-1]};
            diff[s]           = sh[s] - {1'b0, st_reg[s].dmag};
            take[s]           = sh[s] >= {1'b0, st_reg[s].dmag};
            st_next[s+1]      = st_reg[s];
            st_next[s+1].r    = take[s] ? diff[s][DW-1:0] : sh[s][DW-1:0];
            st_next[s+1].low  = st_reg[s].low << 1;
            st_next[s+1].q    = {st_reg[s].q[QB-2:0], take[s]};
        end

        qf      = st_reg[QB].q;
        sat_pos = st_reg[QB].ovf | qf[W] | qf[W-1];
        sat_neg = st_reg[QB].ovf | qf[W] | (qf[W-1] & (qf[W-2:0] != '0));
        sat     = st_reg[QB].neg ? sat_neg : sat_pos;
        if (sat) begin
            mag = st_reg[QB].neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end else begin
            mag = qf[W-1:0];
        end
        res_next.zero = st_reg[QB].dzero;
        if (st_reg[QB].dzero) begin
            res_next.val = '0;
            res_next.sat = 1'b0;
        end else begin
            res_next.val = st_reg[QB].neg ? (~mag + 1'b1) : mag;
            res_next.sat = sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            sv_reg <= '0;
            vf_reg <= 1'b0;
        end else if (ce) begin
            v1_reg <= in_valid;
            sv_reg <= {sv_reg[QB-1:0], v1_reg};
            vf_reg <= sv_reg[QB];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            nabs_reg  <= nabs_next;
            neg1_reg  <= adj[AW-1] ^ info.dneg;
            info1_reg <= info;
            st_reg    <= st_next;
            res_reg   <= res_next;
        end
    end

    assign out_valid = vf_reg;
    assign res       = res_reg;

endmodule

@@ rtl/mi3_merge.sv @@
// Merge of the nine lanes into one result, with a two-entry output queue.
module mi3_merge (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [8:0]           lane_valid,
    input  mi3_pkg::lane_res_t   lane_res [9],
    output logic                 ce,
    input  logic                 m_ready,
    output logic                 m_valid,
    output mi3_pkg::out_t        m_data
);
    import mi3_pkg::*;

    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    out_t       q0_reg;
    out_t       q0_next;
    out_t       q1_reg;
    out_t       q1_next;
    out_t       item;
    logic [8:0] sat_vec;
    logic [8:0] zero_vec;
    logic       push;
    logic       pop;

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            sat_vec[k]  = lane_res[k].sat;
            zero_vec[k] = lane_res[k].zero;
        end
        item.inv00     = lane_res[0].val;
        item.inv01     = lane_res[1].val;
        item.inv02     = lane_res[2].val;
        item.inv10     = lane_res[3].val;
        item.inv11     = lane_res[4].val;
        item.inv12     = lane_res[5].val;
        item.inv20     = lane_res[6].val;
        item.inv21     = lane_res[7].val;
        item.inv22     = lane_res[8].val;
        item.singular  = lane_res[0].zero;
        item.saturated = |sat_vec;
    end

    // pipeline moves while the queue can absorb one more result
    assign ce   = (cnt_reg != 2'd2);
    assign push = ce & lane_valid[0];
    assign pop  = (cnt_reg != 2'd0) & m_ready;

    always_comb begin
        q0_next  = q0_reg;
        q1_next  = q1_reg;
        cnt_next = cnt_reg;
        priority if (push && pop) begin
            if (cnt_reg == 2'd1) begin
                q0_next = item;
            end else begin
                q0_next = q1_reg;
                q1_next = item;
            end
        end else if (pop) begin
            q0_next  = q1_reg;
            cnt_next = cnt_reg - 2'd1;
        end else if (push) begin
            if (cnt_reg == 2'd0) begin
                q0_next = item;
            end else begin
                q1_next = item;
            end
            cnt_next = cnt_reg + 2'd1;
        end else begin
            cnt_next = cnt_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        q0_reg <= q0_next;
        q1_reg <= q1_next;
    end

    assign m_valid = (cnt_reg != 2'd0);
    assign m_data  = q0_reg;

    a_lanes_in_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (lane_valid == 9'h000) || (lane_valid == 9'h1ff))
        else $error("divider lanes out of step");

    a_zero_agree: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> ((zero_vec == 9'h000) || (zero_vec == 9'h1ff)))
        else $error("lanes disagree on singular determinant");

    a_singular_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && item.singular) |-> !item.saturated)
        else $error("singular result flagged as saturated");

    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd2) |=> (cnt_reg != 2'd0) && (cnt_reg != 2'd3))
        else $error("output queue count slipped");

endmodule

@@ rtl/matrix3x3_inverse_unit.sv @@
// Top level of the 3x3 matrix inverse block.
// Inverts one signed fixed-point 3x3 matrix per transaction by the adjugate
// method. Each transaction carries nine entries in row-major order; each
// result carries the nine inverse entries in the same format, truncated
// toward zero and clipped to range, plus a singular flag (exact determinant
// is zero; all entries then read zero) and a saturated flag (some entry was
// clipped). Throughput is one matrix per clock while the output queue is
// not full. An accepted matrix passes through the cofactor products, the
// determinant and a divider lane, whose restoring divider develops one
// quotient bit per stage, and then the output queue before m_valid. The nine
// lanes run in parallel, one per inverse entry, and a merge stage packs
// their results and ORs the clip flags. A two-entry output queue decouples
// the sides: s_ready comes from a register and stays high while one result
// waits at the output, dropping only when two are queued.
module matrix3x3_inverse_unit #(
    parameter int FRAC_BITS = mi3_pkg::FRAC_BITS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  mi3_pkg::in_t     s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output mi3_pkg::out_t    m_data
);
    import mi3_pkg::*;

    // global advance for every pipeline stage
    logic                 ce;
    logic                 adj_valid;
    logic signed [AW-1:0] adj [9];
    elem_t                row0 [3];
    logic                 info_valid;
    det_info_t            info;
    logic signed [AW-1:0] adj_d [9];
    logic [8:0]           lane_valid;
    lane_res_t            lane_res [9];

    assign s_ready = ce;

    // cofactors: products, then adjugate differences
    mi3_cofactor u_cofactor (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (s_valid),
        .mat       (s_data),
        .adj_valid (adj_valid),
        .adj       (adj),
        .row0      (row0)
    );

    // determinant by first-row expansion, adjugate delayed alongside
    mi3_det u_det (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ce         (ce),
        .adj_valid  (adj_valid),
        .adj        (adj),
        .row0       (row0),
        .info_valid (info_valid),
        .info       (info),
        .adj_out    (adj_d)
    );

    // one divider lane per inverse entry
    for (genvar k = 0; k < 9; k++) begin : g_lane
        mi3_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ce        (ce),
            .in_valid  (info_valid),
            .adj       (adj_d[k]),
            .info      (info),
            .out_valid (lane_valid[k]),
            .res       (lane_res[k])
        );
    end

    // pack lanes, output queue, backpressure
    mi3_merge u_merge (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .lane_valid (lane_valid),
        .lane_res   (lane_res),
        .ce         (ce),
        .m_ready    (m_ready),
        .m_valid    (m_valid),
        .m_data     (m_data)
    );

endmodule
